[hdl/vfc_pkg.sv]
`default_nettype none
package vfc_pkg;

  // Chunk dimensions
  localparam int SIZE_X_DEF = 16;
  localparam int SIZE_Y_DEF = 16;
  localparam int SIZE_Z_DEF = 256;

  // Stored voxel width
  localparam int VOXEL_W = 8;

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Y = 8'd1;

  // Input item kinds
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

endpackage
`default_nettype wire

[hdl/vfc_ram.sv]
`default_nettype none
module vfc_ram #(
  parameter int WIDTH = vfc_pkg::VOXEL_W,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[hdl/voxel_face_culling.sv]
// Voxel chunk face culler.
//
// Input stream (s_*): one beat carries a load, a query or a vertex counter
// clear, selected by s_tuser. A load writes one voxel of the chunk store and
// a clear zeroes the running vertex counter; both finish in the cycle they
// are accepted. A query reads the named voxel and its six neighbours from
// the single-port store, one read a cycle, then emits one beat per exposed
// face on the output stream (m_*), bottom, top, -y, +y, -x, +x, with m_tlast
// on the final face. Empty voxels and indexes outside the chunk give nothing.
// A query occupies the block through its seven store reads, which share the
// one memory port, and through the emission of its faces.
// The last face of a query waits in the output register while the next beat
// is already accepted. When the receiver stalls, the output register holds
// and face emission pauses; s_tready stays low until the query is done.
// Configuration (cfg_*) sets the chunk position; write it while idle.
// Reset clears the vertex counter, the chunk position and all handshake
// state. The voxel store is not cleared: load a voxel before querying it or
// any voxel next to it.
`default_nettype none
module voxel_face_culling #(
  parameter int SIZE_X = vfc_pkg::SIZE_X_DEF,
  parameter int SIZE_Y = vfc_pkg::SIZE_Y_DEF,
  parameter int SIZE_Z = vfc_pkg::SIZE_Z_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [15:0] voxel_index, [23:16] block_value
  input  wire logic [vfc_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] func
  input  wire logic [vfc_pkg::IN_USER_W-1:0]   s_tuser,
  // output stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [19:0] world_x, [39:20] world_y, [47:40] height_z, [50:48] face_dir,
  // [58:51] block_type, [79:59] vertex_base
  output logic      [vfc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                                 m_tlast,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PLANE = SIZE_Z * SIZE_Y;
  localparam int TOTAL = PLANE * SIZE_X;
  localparam int AW    = $clog2(TOTAL);
  localparam int XW    = $clog2(SIZE_X);
  localparam int YW    = $clog2(SIZE_Y);
  localparam int ZW    = $clog2(SIZE_Z);

  // Reciprocal constants: floor(n/d) = (n*M) >> SH for every AW-bit n
  localparam int L_Z  = $clog2(SIZE_Z);
  localparam int SH_Z = AW + L_Z;
  localparam longint unsigned M_Z = ((64'd1 << SH_Z) + SIZE_Z - 1) / SIZE_Z;
  localparam int PW_Z = AW + SH_Z + 1;
  localparam int L_Y  = $clog2(SIZE_Y);
  localparam int SH_Y = AW + L_Y;
  localparam longint unsigned M_Y = ((64'd1 << SH_Y) + SIZE_Y - 1) / SIZE_Y;
  localparam int PW_Y = AW + SH_Y + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;

  // configuration
  logic [15:0] ch_x, ch_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_x <= '0;
      ch_y <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == vfc_pkg::REG_CHUNK_X) begin
        ch_x <= cfg_data;
      end else if (cfg_index == vfc_pkg::REG_CHUNK_Y) begin
        ch_y <= cfg_data;
      end
    end
  end

  // input beat decode
  logic [1:0]  in_func;
  logic [15:0] in_idx;
  logic [7:0]  in_val;
  logic        in_range;
  logic        in_acc;
  logic [AW+15:0] in_idx_ext;

  assign in_func    = s_tuser[1:0];
  assign in_idx     = s_tdata[15:0];
  assign in_val     = s_tdata[23:16];
  assign in_idx_ext = {{AW{1'b0}}, in_idx};
  assign in_range   = (in_idx_ext < (AW+16)'(TOTAL));
  assign s_tready   = (state == S_IDLE);
  assign in_acc     = s_tvalid && s_tready;

  // query registers
  logic [AW-1:0] idx;
  logic [2:0]    rd_k;
  logic          cap_v;
  logic [2:0]    cap_k;
  logic [7:0]    blk;
  logic [5:0]    nb_empty;
  logic [5:0]    mask;
  logic [19:0]   wx, wy;
  logic [20:0]   vertex_count;

  // index decode, free running on the held index
  logic [AW-1:0] q1, q2;
  logic [ZW-1:0] lz;
  logic [YW-1:0] ly;
  logic [XW-1:0] lx;
  logic [PW_Z-1:0] prod_z;
  logic [PW_Y-1:0] prod_y;
  logic [AW-1:0]   z_full, y_full;

  assign prod_z = PW_Z'(idx) * PW_Z'(M_Z);
  assign prod_y = PW_Y'(q1) * PW_Y'(M_Y);
  assign z_full = idx - AW'(q1 * AW'(SIZE_Z));
  assign y_full = q1 - AW'(q2 * AW'(SIZE_Y));

  always_ff @(posedge clk) begin
    q1 <= prod_z[SH_Z +: AW];
    q2 <= prod_y[SH_Y +: AW];
    lz <= z_full[ZW-1:0];
    ly <= y_full[YW-1:0];
    lx <= q2[XW-1:0];
  end

  // store access
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;

  always_comb begin
    case (rd_k)
      3'd1:    rd_addr = idx - AW'(1);
      3'd2:    rd_addr = idx + AW'(1);
      3'd3:    rd_addr = idx - AW'(SIZE_Z);
      3'd4:    rd_addr = idx + AW'(SIZE_Z);
      3'd5:    rd_addr = idx - AW'(PLANE);
      3'd6:    rd_addr = idx + AW'(PLANE);
      default: rd_addr = idx;
    endcase
  end

  assign ram_we   = in_acc && (in_func == vfc_pkg::FUNC_LOAD) && in_range;
  assign ram_addr = (state == S_IDLE) ? in_idx_ext[AW-1:0] : rd_addr;

  vfc_ram #(
    .WIDTH (vfc_pkg::VOXEL_W),
    .DEPTH (TOTAL)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_val),
    .rdata (ram_rdata)
  );

  // exposure: boundary or empty neighbour
  logic [5:0] exposed;
  always_comb begin
    exposed[0] = (lz == '0) || nb_empty[0];
    exposed[1] = (lz == ZW'(SIZE_Z - 1)) || nb_empty[1];
    exposed[2] = (ly == '0) || nb_empty[2];
    exposed[3] = (ly == YW'(SIZE_Y - 1)) || nb_empty[3];
    exposed[4] = (lx == '0) || nb_empty[4];
    exposed[5] = (lx == XW'(SIZE_X - 1)) || nb_empty[5];
  end

  logic [19:0] cx20, cy20;
  assign cx20 = {{4{ch_x[15]}}, ch_x};
  assign cy20 = {{4{ch_y[15]}}, ch_y};

  // lowest pending face
  logic [2:0] face;
  logic [5:0] mask_next;
  always_comb begin
    face = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask[i]) begin
        face = 3'(i);
      end
    end
    mask_next = mask & ~(6'b1 << face);
  end

  // output register
  logic        out_free;
  logic [19:0] o_wx, o_wy;
  logic [7:0]  o_hz;
  logic [2:0]  o_face;
  logic [7:0]  o_blk;
  logic [20:0] o_vb;

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {o_vb, o_blk, o_face, o_hz, o_wy, o_wx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      m_tvalid     <= 1'b0;
      cap_v        <= 1'b0;
      rd_k         <= '0;
    end else begin
      // drop the beat once taken; S_EMIT reloads the register itself
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      // capture the read issued last cycle
      cap_v <= (state == S_READ);
      if (cap_v) begin
        case (cap_k)
          3'd0:    blk <= ram_rdata;
          default: nb_empty[cap_k - 3'd1] <= (ram_rdata == '0);
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_func == vfc_pkg::FUNC_CLEAR) begin
              vertex_count <= '0;
            end else if (in_func == vfc_pkg::FUNC_QUERY && in_range) begin
              idx   <= in_idx_ext[AW-1:0];
              rd_k  <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          cap_k <= rd_k;
          if (rd_k == 3'd6) begin
            state <= S_WAIT;
          end else begin
            rd_k <= rd_k + 3'd1;
          end
        end
        S_WAIT: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          mask <= exposed;
          wx   <= cx20 * 20'(SIZE_X) + 20'(lx);
          wy   <= cy20 * 20'(SIZE_Y) + 20'(ly);
          if (blk == '0 || exposed == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            o_wx         <= wx;
            o_wy         <= wy;
            o_hz         <= 8'(lz);
            o_face       <= face;
            o_blk        <= blk;
            o_vb         <= vertex_count;
            m_tlast      <= (mask_next == '0);
            vertex_count <= vertex_count + 21'd4;
            mask         <= mask_next;
            if (mask_next == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
